// ----- design/spi_flash_command_sequencer_assert.svh -----
// Assertion macros used by the sequencer back end.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef SPI_FLASH_COMMAND_SEQUENCER_ASSERT_SVH
`define SPI_FLASH_COMMAND_SEQUENCER_ASSERT_SVH
// Same-cycle implication.
`define SFCS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sfcs: same-cycle check failed");
// Next-cycle implication.
`define SFCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sfcs: next-cycle check failed");
`endif

// ----- design/sfcs_pkg.sv -----
`default_nettype none
package sfcs_pkg;

  // Classified operation of one input transaction.
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_SLOT  = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // Sequencer phase, one-hot.
  typedef enum logic [4:0] {
    PH_IDLE     = 5'b00001,
    PH_FRAME    = 5'b00010,
    PH_RXTAIL   = 5'b00100,
    PH_POLLWAIT = 5'b01000,
    PH_WAKE     = 5'b10000
  } phase_e;

  // Kind of the frame in flight.
  typedef enum logic [2:0] {
    K_HOSTRX = 3'd0,
    K_POLL   = 3'd1,
    K_WREN   = 3'd2,
    K_PROG   = 3'd3,
    K_CMD    = 3'd4
  } kind_e;

  // Host command codes.
  localparam logic [3:0] CMD_READ    = 4'd0;
  localparam logic [3:0] CMD_WRITE   = 4'd1;
  localparam logic [3:0] CMD_SECTOR  = 4'd2;
  localparam logic [3:0] CMD_ERASE32 = 4'd3;
  localparam logic [3:0] CMD_ERASE64 = 4'd4;
  localparam logic [3:0] CMD_CHIP    = 4'd5;
  localparam logic [3:0] CMD_PDOWN   = 4'd6;
  localparam logic [3:0] CMD_PUP     = 4'd7;
  localparam logic [3:0] CMD_STATUS  = 4'd8;

  // Completion status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_RANGE   = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_DEVICE_MODEL = 1'b0;
  localparam logic CFG_BUSY_TIMEOUT = 1'b1;

  // Flash opcodes.
  localparam logic [7:0] OPC_READ3   = 8'h03;
  localparam logic [7:0] OPC_READ4   = 8'h13;
  localparam logic [7:0] OPC_PROG3   = 8'h02;
  localparam logic [7:0] OPC_PROG4   = 8'h12;
  localparam logic [7:0] OPC_SE3     = 8'h20;
  localparam logic [7:0] OPC_SE4     = 8'h21;
  localparam logic [7:0] OPC_BE32    = 8'h52;
  localparam logic [7:0] OPC_BE64_3  = 8'hD8;
  localparam logic [7:0] OPC_BE64_4  = 8'hDC;
  localparam logic [7:0] OPC_CHIP    = 8'hC7;
  localparam logic [7:0] OPC_WREN    = 8'h06;
  localparam logic [7:0] OPC_RDSR    = 8'h05;
  localparam logic [7:0] OPC_PDOWN   = 8'hB9;
  localparam logic [7:0] OPC_PUP     = 8'hAB;
  localparam logic [7:0] DUMMY_BYTE  = 8'hFF;

  localparam logic [32:0] BLOCK32_BYTES = 33'd32768;
  localparam logic [32:0] BLOCK64_BYTES = 33'd65536;
  localparam int unsigned BLOCK32_INT   = 32768;

  // Depth of the queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // One classified input transaction.
  typedef struct packed {
    op_e         op;
    logic [3:0]  command;
    logic [31:0] address;
    logic [26:0] length;
    logic [7:0]  rx_byte;
    logic [7:0]  payload_byte;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       frame_last;
    logic       payload_taken;
    logic       read_valid;
    logic [7:0] read_data;
    logic       done_res;
    logic [1:0] status;
    logic       busy_res;
  } result_t;

  // Queue status seen by the front.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Capacity in bytes for a device model; unknown models have none.
  function automatic logic [26:0] cap_of(input logic [2:0] m);
    logic [26:0] c;
    begin
      case (m)
        3'd1: c = 27'h0200000;
        3'd2: c = 27'h0400000;
        3'd3: c = 27'h0800000;
        3'd4: c = 27'h1000000;
        3'd5: c = 27'h2000000;
        3'd6: c = 27'h4000000;
        default: c = 27'd0;
      endcase
      return c;
    end
  endfunction

  // Address plus count must not pass the capacity; no wrap.
  function automatic logic fits(input logic [31:0] a, input logic [32:0] n,
                                input logic [26:0] cap);
    return (({1'b0, a} + n) <= {6'd0, cap});
  endfunction

endpackage
`default_nettype wire

// ----- design/sfcs_queue.sv -----
`default_nettype none
module sfcs_queue import sfcs_pkg::*; (
  input  wire    clk_i,
  input  wire    rst_ni,
  input  wire    push_i,
  input  item_t  push_item_i,
  input  wire    pop_i,
  output item_t  pop_item_o,
  output qstat_t stat_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  item_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == CntW'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_item_o   = mem_q[rd_q];

  // Pointer and count update with wrap at the queue depth.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule
`default_nettype wire

// ----- design/sfcs_front.sv -----
`default_nettype none
module sfcs_front import sfcs_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [1:0]  op_i,
  input  wire  [3:0]  command_i,
  input  wire  [31:0] address_i,
  input  wire  [26:0] length_i,
  input  wire  [7:0]  rx_byte_i,
  input  wire  [7:0]  payload_byte_i,
  input  qstat_t      qstat_i,
  output logic        push_o,
  output item_t       push_item_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  item_t item_d;
  logic  accept;

  // The stage holds one transaction and hands it to the queue when there is room.
  assign in_stall_o  = valid_q && qstat_i.full;
  assign accept      = in_valid_i && !in_stall_o;
  assign push_o      = valid_q;
  assign push_item_o = item_q;

  // Classify the operation; command, address and length are cleared unless it is a start.
  always_comb begin
    item_d              = '0;
    item_d.rx_byte      = rx_byte_i;
    item_d.payload_byte = payload_byte_i;
    case (op_i)
      OP_START: begin
        item_d.op      = OP_START;
        item_d.command = command_i;
        item_d.address = address_i;
        item_d.length  = length_i;
      end
      OP_SLOT: item_d.op = OP_SLOT;
      OP_TICK: item_d.op = OP_TICK;
      default: item_d.op = OP_NONE;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (valid_q && !qstat_i.full) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule
`default_nettype wire

// ----- design/sfcs_back.sv -----
`default_nettype none
module sfcs_back import sfcs_pkg::*; #(
  parameter int unsigned PAGE_BYTES   = 256,
  parameter int unsigned SECTOR_BYTES = 4096
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire         cfg_index_i,
  input  wire  [15:0] cfg_data_i,
  input  qstat_t      qstat_i,
  input  item_t       item_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output result_t     res_o
);

  `include "spi_flash_command_sequencer_assert.svh"

  localparam int unsigned PageW    = $clog2(PAGE_BYTES);
  localparam int unsigned ChunkW   = $clog2(PAGE_BYTES + 1);
  localparam int unsigned SecLimit = (BLOCK32_INT + SECTOR_BYTES - 1) / SECTOR_BYTES;
  localparam int unsigned SecW     = $clog2(SecLimit + 1);

  // Configuration registers.
  logic [2:0]  model_q;
  logic [15:0] timeout_q;

  // Sequencer state.
  phase_e            phase_q, phase_d;
  kind_e             kind_q, kind_d;
  logic [3:0]        act_q, act_d;
  logic [31:0]       addr_q, addr_d;
  logic [26:0]       left_q, left_d;
  logic [ChunkW-1:0] chunk_q, chunk_d;
  logic [2:0]        fi_q, fi_d;
  logic [17:0]       el_q, el_d;
  logic [SecW-1:0]   sc_q, sc_d;
  logic              pd_q, pd_d;
  logic              rxd_q, rxd_d;
  logic              w4_q, w4_d;
  logic [26:0]       cap_q, cap_d;
  logic [17:0]       lim_q, lim_d;

  logic    out_valid_q, out_valid_d;
  result_t res_q, res_d;

  // Next-state locals.
  logic              open_req, fin_req, last, dummy, was_due;
  kind_e             open_kind;
  logic [1:0]        fin_st;
  logic [2:0]        nh, ab;
  logic [1:0]        sel;
  logic [7:0]        b, opc, abyte;
  logic [ChunkW-1:0] room;
  logic [26:0]       dleft;
  logic [26:0]       cap_n;
  logic              w4_n;

  // A queued transaction is taken whenever the result register can be refilled.
  assign pop_o       = !qstat_i.empty && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  // Frame header length, opcode and address byte for the frame in flight.
  always_comb begin
    ab = 3'd0;
    case (kind_q)
      K_PROG: ab = w4_q ? 3'd4 : 3'd3;
      K_HOSTRX: ab = (act_q == CMD_READ) ? (w4_q ? 3'd4 : 3'd3) : 3'd0;
      K_CMD: begin
        if (act_q == CMD_SECTOR || act_q == CMD_ERASE32 || act_q == CMD_ERASE64) begin
          ab = w4_q ? 3'd4 : 3'd3;
        end
      end
      default: ab = 3'd0;
    endcase
    nh = ab + 3'd1;

    case (kind_q)
      K_WREN: opc = OPC_WREN;
      K_POLL: opc = OPC_RDSR;
      K_HOSTRX: opc = (act_q == CMD_STATUS) ? OPC_RDSR : (w4_q ? OPC_READ4 : OPC_READ3);
      K_PROG: opc = w4_q ? OPC_PROG4 : OPC_PROG3;
      default: begin
        case (act_q)
          CMD_SECTOR:  opc = w4_q ? OPC_SE4 : OPC_SE3;
          CMD_ERASE32: opc = w4_q ? OPC_SE4 : OPC_BE32;
          CMD_ERASE64: opc = w4_q ? OPC_BE64_4 : OPC_BE64_3;
          CMD_CHIP:    opc = OPC_CHIP;
          CMD_PDOWN:   opc = OPC_PDOWN;
          default:     opc = OPC_PUP;
        endcase
      end
    endcase

    sel = 2'(nh - 3'd1 - fi_q);
    case (sel)
      2'd0: abyte = addr_q[7:0];
      2'd1: abyte = addr_q[15:8];
      2'd2: abyte = addr_q[23:16];
      default: abyte = addr_q[31:24];
    endcase

    case (kind_q)
      K_HOSTRX: dleft = left_q;
      K_PROG, K_POLL: dleft = 27'(chunk_q);
      default: dleft = 27'd0;
    endcase
  end

  // One transaction per cycle while the result register can take it: start, byte slot or millisecond tick.
  always_comb begin
    phase_d = phase_q;
    kind_d  = kind_q;
    act_d   = act_q;
    addr_d  = addr_q;
    left_d  = left_q;
    chunk_d = chunk_q;
    fi_d    = fi_q;
    el_d    = el_q;
    sc_d    = sc_q;
    pd_d    = pd_q;
    rxd_d   = rxd_q;
    w4_d    = w4_q;
    cap_d   = cap_q;
    lim_d   = lim_q;
    res_d     = '0;
    open_req  = 1'b0;
    open_kind = K_HOSTRX;
    fin_req   = 1'b0;
    fin_st    = ST_OK;
    last      = 1'b0;
    dummy     = 1'b0;
    was_due   = rxd_q;
    b         = 8'd0;
    room      = '0;
    cap_n     = cap_of(model_q);
    w4_n      = (model_q == 3'd5) || (model_q == 3'd6);

    case (item_i.op)
      OP_START: begin
        if (phase_q == PH_IDLE) begin
          act_d   = item_i.command;
          addr_d  = item_i.address;
          left_d  = item_i.length;
          chunk_d = '0;
          fi_d    = 3'd0;
          el_d    = 18'd0;
          sc_d    = '0;
          pd_d    = 1'b0;
          rxd_d   = 1'b0;
          w4_d    = w4_n;
          cap_d   = cap_n;
          lim_d   = {2'd0, timeout_q};
          case (item_i.command)
            CMD_READ: begin
              if (!fits(item_i.address, {6'd0, item_i.length}, cap_n)) begin
                fin_req = 1'b1;
                fin_st  = ST_RANGE;
              end else begin
                open_req  = 1'b1;
                open_kind = K_HOSTRX;
              end
            end
            CMD_WRITE: begin
              if (!fits(item_i.address, {6'd0, item_i.length}, cap_n)) begin
                fin_req = 1'b1;
                fin_st  = ST_RANGE;
              end else if (item_i.length == 27'd0) begin
                fin_req = 1'b1;
              end else begin
                open_req  = 1'b1;
                open_kind = K_WREN;
              end
            end
            CMD_SECTOR: begin
              if (!fits(item_i.address, 33'(SECTOR_BYTES), cap_n)) begin
                fin_req = 1'b1;
                fin_st  = ST_RANGE;
              end else begin
                open_req  = 1'b1;
                open_kind = K_WREN;
              end
            end
            CMD_ERASE32: begin
              if (!fits(item_i.address, BLOCK32_BYTES, cap_n) ||
                  (w4_n && !fits(item_i.address, 33'(SECTOR_BYTES), cap_n))) begin
                fin_req = 1'b1;
                fin_st  = ST_RANGE;
              end else begin
                open_req  = 1'b1;
                open_kind = K_WREN;
              end
            end
            CMD_ERASE64: begin
              if (!fits(item_i.address, BLOCK64_BYTES, cap_n)) begin
                fin_req = 1'b1;
                fin_st  = ST_RANGE;
              end else begin
                open_req  = 1'b1;
                open_kind = K_WREN;
              end
            end
            CMD_CHIP: begin
              lim_d     = {2'd0, timeout_q} + {1'b0, timeout_q, 1'b0};
              open_req  = 1'b1;
              open_kind = K_WREN;
            end
            CMD_PDOWN, CMD_PUP: begin
              open_req  = 1'b1;
              open_kind = K_CMD;
            end
            CMD_STATUS: begin
              left_d    = 27'd1;
              open_req  = 1'b1;
              open_kind = K_HOSTRX;
            end
            default: fin_req = 1'b1;
          endcase
        end
      end

      OP_SLOT: begin
        if (phase_q == PH_FRAME) begin
          rxd_d = 1'b0;
          if (kind_q == K_HOSTRX && was_due) begin
            res_d.read_valid = 1'b1;
            res_d.read_data  = item_i.rx_byte;
          end
          if (fi_q < nh) begin
            b    = (fi_q == 3'd0) ? opc : abyte;
            fi_d = fi_q + 3'd1;
            last = (fi_d >= nh) && (dleft == 27'd0);
          end else if (kind_q == K_PROG) begin
            b                   = item_i.payload_byte;
            res_d.payload_taken = 1'b1;
            addr_d              = addr_q + 32'd1;
            if (left_q != 27'd0) left_d = left_q - 27'd1;
            if (chunk_q != '0) chunk_d = chunk_q - 1'b1;
            last = (chunk_d == '0);
          end else begin
            b     = DUMMY_BYTE;
            dummy = 1'b1;
            rxd_d = 1'b1;
            if (kind_q == K_HOSTRX) begin
              if (left_q != 27'd0) left_d = left_q - 27'd1;
              last = (left_d == 27'd0);
            end else begin
              if (chunk_q != '0) chunk_d = chunk_q - 1'b1;
              last = (chunk_d == '0);
            end
          end
          res_d.tx_valid   = 1'b1;
          res_d.tx_byte    = b;
          res_d.frame_last = last;
          // Frame end: decide what follows.
          if (last) begin
            case (kind_q)
              K_WREN: begin
                open_req  = 1'b1;
                open_kind = (act_q == CMD_WRITE) ? K_PROG : K_CMD;
              end
              K_PROG: begin
                el_d = 18'd0;
                if (lim_q == 18'd0) begin
                  fin_req = 1'b1;
                  fin_st  = ST_TIMEOUT;
                end else begin
                  open_req  = 1'b1;
                  open_kind = K_POLL;
                end
              end
              K_CMD: begin
                if (act_q == CMD_PDOWN) begin
                  fin_req = 1'b1;
                end else if (act_q == CMD_PUP) begin
                  phase_d = PH_WAKE;
                  el_d    = 18'd0;
                end else begin
                  el_d = 18'd0;
                  if (lim_q == 18'd0) begin
                    fin_req = 1'b1;
                    fin_st  = ST_TIMEOUT;
                  end else begin
                    open_req  = 1'b1;
                    open_kind = K_POLL;
                  end
                end
              end
              K_HOSTRX: begin
                if (dummy) phase_d = PH_RXTAIL;
                else fin_req = 1'b1;
              end
              default: phase_d = PH_RXTAIL;
            endcase
          end
        end else if (phase_q == PH_RXTAIL) begin
          rxd_d = 1'b0;
          if (kind_q == K_HOSTRX) begin
            res_d.read_valid = 1'b1;
            res_d.read_data  = item_i.rx_byte;
            fin_req          = 1'b1;
          end else if (!item_i.rx_byte[0]) begin
            // Busy cleared: next page, next sector or done.
            if (act_q == CMD_WRITE) begin
              if (left_q == 27'd0) begin
                fin_req = 1'b1;
              end else begin
                open_req  = 1'b1;
                open_kind = K_WREN;
              end
            end else if (act_q == CMD_ERASE32 && w4_q) begin
              sc_d   = sc_q + 1'b1;
              addr_d = addr_q + 32'(SECTOR_BYTES);
              if (sc_d >= SecW'(SecLimit)) begin
                fin_req = 1'b1;
              end else if (!fits(addr_d, 33'(SECTOR_BYTES), cap_q)) begin
                fin_req = 1'b1;
                fin_st  = ST_RANGE;
              end else begin
                open_req  = 1'b1;
                open_kind = K_WREN;
              end
            end else begin
              fin_req = 1'b1;
            end
          end else begin
            phase_d = PH_POLLWAIT;
            pd_d    = 1'b1;
          end
        end
      end

      OP_TICK: begin
        if (phase_q == PH_POLLWAIT) begin
          el_d = el_q + 18'd1;
          if (el_d >= lim_q) begin
            fin_req = 1'b1;
            fin_st  = ST_TIMEOUT;
          end else begin
            open_req  = 1'b1;
            open_kind = K_POLL;
          end
        end else if (phase_q == PH_WAKE) begin
          el_d = el_q + 18'd1;
          if (el_d >= 18'd3) fin_req = 1'b1;
        end
      end

      default: ;
    endcase

    // Open a new frame; a program frame stops at the page boundary.
    if (open_req) begin
      kind_d  = open_kind;
      fi_d    = 3'd0;
      phase_d = PH_FRAME;
      pd_d    = 1'b0;
      room    = ChunkW'(PAGE_BYTES) - ChunkW'(addr_d[PageW-1:0]);
      if (open_kind == K_PROG) begin
        chunk_d = (left_d < 27'(room)) ? left_d[ChunkW-1:0] : room;
      end else if (open_kind == K_POLL) begin
        chunk_d = ChunkW'(1);
      end
    end

    // Finish the command.
    if (fin_req) begin
      res_d.done_res = 1'b1;
      res_d.status   = fin_st;
      phase_d        = PH_IDLE;
      pd_d           = 1'b0;
    end

    res_d.busy_res = (phase_d != PH_IDLE);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      model_q   <= 3'd0;
      timeout_q <= 16'd5000;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DEVICE_MODEL: model_q <= cfg_data_i[2:0];
        CFG_BUSY_TIMEOUT: timeout_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer state advances only on a taken transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      kind_q      <= K_HOSTRX;
      act_q       <= 4'd0;
      addr_q      <= 32'd0;
      left_q      <= 27'd0;
      chunk_q     <= '0;
      fi_q        <= 3'd0;
      el_q        <= 18'd0;
      sc_q        <= '0;
      pd_q        <= 1'b0;
      rxd_q       <= 1'b0;
      w4_q        <= 1'b0;
      cap_q       <= 27'd0;
      lim_q       <= 18'd0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        phase_q <= phase_d;
        kind_q  <= kind_d;
        act_q   <= act_d;
        addr_q  <= addr_d;
        left_q  <= left_d;
        chunk_q <= chunk_d;
        fi_q    <= fi_d;
        el_q    <= el_d;
        sc_q    <= sc_d;
        pd_q    <= pd_d;
        rxd_q   <= rxd_d;
        w4_q    <= w4_d;
        cap_q   <= cap_d;
        lim_q   <= lim_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

  // A nonzero status only comes with the end of a command.
  `SFCS_ASSERT_NOW(a_status_done, out_valid_q && res_q.status != ST_OK, res_q.done_res)
  // A finished command leaves the block idle.
  `SFCS_ASSERT_NOW(a_done_idle, out_valid_q && res_q.done_res, !res_q.busy_res)
  // Program data is only taken while a byte goes out.
  `SFCS_ASSERT_NOW(a_taken_tx, out_valid_q && res_q.payload_taken,
                   res_q.tx_valid && !res_q.read_valid)
  // Slots and ticks never leave the idle phase.
  `SFCS_ASSERT_NEXT(a_idle_holds, pop_o && phase_q == PH_IDLE && item_i.op != OP_START,
                    phase_q == PH_IDLE)

endmodule
`default_nettype wire

// ----- design/spi_flash_command_sequencer.sv -----
// SPI NOR flash command sequencer.
// Input channel (in_valid_i / in_stall_o) carries one transaction per cycle: a start
// command, an SPI byte slot or a millisecond tick. Output channel (out_valid_o /
// out_stall_i) returns exactly one result transaction for every input transaction,
// in order: the byte to send with its frame mark, any byte for the host, and the
// done, status and busy flags.
// From input transaction to result the path runs through a classify register,
// a two-entry queue and the result register. Throughput is one transaction per
// cycle while the receiver does not stall, with one sequencer step per transaction.
// The configuration port (cfg_we_i, cfg_index_i, cfg_data_i) writes the device model
// and busy timeout; they are sampled when a command starts, so write them while idle.
// When the receiver stalls, the result register holds and the queue fills; the input
// side stalls only once the queue and the classify register are both full.
// Reset clears the sequencer to idle, the device model to unknown and the busy
// timeout to 5000 ms; no result is pending after reset.
`default_nettype none
module spi_flash_command_sequencer import sfcs_pkg::*; #(
  parameter int unsigned PAGE_BYTES   = 256,
  parameter int unsigned SECTOR_BYTES = 4096
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire         cfg_index_i,
  input  wire  [15:0] cfg_data_i,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [1:0]  op_i,
  input  wire  [3:0]  command_i,
  input  wire  [31:0] address_i,
  input  wire  [26:0] length_i,
  input  wire  [7:0]  rx_byte_i,
  input  wire  [7:0]  payload_byte_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic        tx_valid_o,
  output logic [7:0]  tx_byte_o,
  output logic        frame_last_o,
  output logic        payload_taken_o,
  output logic        read_valid_o,
  output logic [7:0]  read_data_o,
  output logic        done_res_o,
  output logic [1:0]  status_o,
  output logic        busy_res_o
);

  qstat_t  qstat;
  logic    push, pop;
  item_t   push_item, pop_item;
  result_t res;

  // Front end: accept and classify.
  sfcs_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .command_i      (command_i),
    .address_i      (address_i),
    .length_i       (length_i),
    .rx_byte_i      (rx_byte_i),
    .payload_byte_i (payload_byte_i),
    .qstat_i        (qstat),
    .push_o         (push),
    .push_item_o    (push_item)
  );

  // Queue between front and back.
  sfcs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .stat_o      (qstat)
  );

  // Back end: command sequencing and result register.
  sfcs_back #(
    .PAGE_BYTES   (PAGE_BYTES),
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .qstat_i     (qstat),
    .item_i      (pop_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign tx_valid_o      = res.tx_valid;
  assign tx_byte_o       = res.tx_byte;
  assign frame_last_o    = res.frame_last;
  assign payload_taken_o = res.payload_taken;
  assign read_valid_o    = res.read_valid;
  assign read_data_o     = res.read_data;
  assign done_res_o      = res.done_res;
  assign status_o        = res.status;
  assign busy_res_o      = res.busy_res;

endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
`default_nettype none
module tb_top;
  import sfcs_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  op_i = OP_NONE;
  logic [3:0]  command_i = '0;
  logic [31:0] address_i = '0;
  logic [26:0] length_i = '0;
  logic [7:0]  rx_byte_i = '0;
  logic [7:0]  payload_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        tx_valid_o, frame_last_o, payload_taken_o, read_valid_o;
  logic [7:0]  tx_byte_o, read_data_o;
  logic        done_res_o, busy_res_o;
  logic [1:0]  status_o;

  spi_flash_command_sequencer dut (.*);

  // Clock; the single reset pulse is released in the main sequence.
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #100_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Shadow copy of the sequencer, updated once per accepted transaction.
  logic [2:0]  sh_model = 3'd0;
  logic [15:0] sh_timeout = 16'd5000;
  phase_e      sh_phase = PH_IDLE;
  kind_e       sh_kind = K_HOSTRX;
  logic [3:0]  sh_cmd = '0;
  logic [31:0] sh_addr = '0;
  logic [26:0] sh_left = '0;
  logic [8:0]  sh_chunk = '0;
  int          sh_fidx = 0;
  int          sh_elapsed = 0;
  int          sh_sectors = 0;
  bit          sh_rxdue = 0, sh_wide = 0;
  longint unsigned sh_cap = 0;
  int          sh_limit = 0;
  result_t     acc;

  result_t expected_q[$];
  int          errors = 0;
  int          items_sent = 0;
  bit          quiet = 0;

  function automatic bit fits_cap(logic [31:0] a, longint unsigned n);
    return (longint'({32'd0, a}) + n) <= sh_cap;
  endfunction

  function automatic void complete(logic [1:0] st);
    acc.done_res = 1'b1;
    acc.status = st;
    sh_phase = PH_IDLE;
  endfunction

  function automatic void open_frame(kind_e k);
    int room;
    sh_kind = k;
    sh_fidx = 0;
    sh_phase = PH_FRAME;
    if (k == K_PROG) begin
      room = 256 - (sh_addr % 256);
      sh_chunk = (sh_left < room) ? sh_left[8:0] : room[8:0];
    end else if (k == K_POLL) begin
      sh_chunk = 9'd1;
    end
  endfunction

  function automatic int addr_count();
    int w = sh_wide ? 4 : 3;
    if (sh_kind == K_PROG) return w;
    if (sh_kind == K_HOSTRX) return (sh_cmd == CMD_READ) ? w : 0;
    if (sh_kind == K_CMD && sh_cmd >= CMD_SECTOR && sh_cmd <= CMD_ERASE64) return w;
    return 0;
  endfunction

  function automatic logic [7:0] frame_opcode();
    case (sh_kind)
      K_WREN:   return OPC_WREN;
      K_POLL:   return OPC_RDSR;
      K_HOSTRX: return (sh_cmd == CMD_STATUS) ? OPC_RDSR : (sh_wide ? OPC_READ4 : OPC_READ3);
      K_PROG:   return sh_wide ? OPC_PROG4 : OPC_PROG3;
      default: ;
    endcase
    case (sh_cmd)
      CMD_SECTOR:  return sh_wide ? OPC_SE4 : OPC_SE3;
      CMD_ERASE32: return sh_wide ? OPC_SE4 : OPC_BE32;
      CMD_ERASE64: return sh_wide ? OPC_BE64_4 : OPC_BE64_3;
      CMD_CHIP:    return OPC_CHIP;
      CMD_PDOWN:   return OPC_PDOWN;
      default:     return OPC_PUP;
    endcase
  endfunction

  function automatic int data_left();
    if (sh_kind == K_HOSTRX) return sh_left;
    if (sh_kind == K_PROG || sh_kind == K_POLL) return sh_chunk;
    return 0;
  endfunction

  // Busy bit came back clear.
  function automatic void poll_clear();
    if (sh_cmd == CMD_WRITE) begin
      if (sh_left == 0) complete(ST_OK);
      else open_frame(K_WREN);
    end else if (sh_cmd == CMD_ERASE32 && sh_wide) begin
      sh_sectors++;
      sh_addr = sh_addr + 32'd4096;
      if (sh_sectors * 4096 >= BLOCK32_INT) complete(ST_OK);
      else if (!fits_cap(sh_addr, 4096)) complete(ST_RANGE);
      else open_frame(K_WREN);
    end else begin
      complete(ST_OK);
    end
  endfunction

  function automatic void close_frame(bit dummy);
    case (sh_kind)
      K_WREN: open_frame(sh_cmd == CMD_WRITE ? K_PROG : K_CMD);
      K_PROG: begin
        sh_elapsed = 0;
        if (sh_limit == 0) complete(ST_TIMEOUT);
        else open_frame(K_POLL);
      end
      K_CMD: begin
        if (sh_cmd == CMD_PDOWN) complete(ST_OK);
        else if (sh_cmd == CMD_PUP) begin
          sh_phase = PH_WAKE;
          sh_elapsed = 0;
        end else begin
          sh_elapsed = 0;
          if (sh_limit == 0) complete(ST_TIMEOUT);
          else open_frame(K_POLL);
        end
      end
      K_HOSTRX: begin
        if (dummy) sh_phase = PH_RXTAIL;
        else complete(ST_OK);
      end
      default: sh_phase = PH_RXTAIL;
    endcase
  endfunction

  function automatic void start_cmd(logic [3:0] c, logic [31:0] a, logic [26:0] n);
    sh_cmd = c;
    sh_addr = a;
    sh_left = n;
    sh_chunk = '0;
    sh_fidx = 0;
    sh_elapsed = 0;
    sh_sectors = 0;
    sh_rxdue = 0;
    sh_wide = (sh_model == 3'd5 || sh_model == 3'd6);
    sh_cap = (sh_model >= 3'd1 && sh_model <= 3'd6) ? (64'd2097152 << (sh_model - 1)) : 0;
    sh_limit = sh_timeout;
    case (c)
      CMD_READ:    if (!fits_cap(a, n)) complete(ST_RANGE); else open_frame(K_HOSTRX);
      CMD_WRITE: begin
        if (!fits_cap(a, n)) complete(ST_RANGE);
        else if (n == 0) complete(ST_OK);
        else open_frame(K_WREN);
      end
      CMD_SECTOR:  if (!fits_cap(a, 4096)) complete(ST_RANGE); else open_frame(K_WREN);
      CMD_ERASE32: begin
        if (!fits_cap(a, 32768) || (sh_wide && !fits_cap(a, 4096))) complete(ST_RANGE);
        else open_frame(K_WREN);
      end
      CMD_ERASE64: if (!fits_cap(a, 65536)) complete(ST_RANGE); else open_frame(K_WREN);
      CMD_CHIP: begin
        sh_limit = sh_timeout * 3;
        open_frame(K_WREN);
      end
      CMD_PDOWN, CMD_PUP: open_frame(K_CMD);
      CMD_STATUS: begin
        sh_left = 27'd1;
        open_frame(K_HOSTRX);
      end
      default: complete(ST_OK);
    endcase
  endfunction

  function automatic void slot_step(logic [7:0] rx, logic [7:0] pl);
    int nh;
    bit was_due, dummy, last;
    logic [7:0] b;
    dummy = 0;
    if (sh_phase == PH_FRAME) begin
      nh = 1 + addr_count();
      was_due = sh_rxdue;
      sh_rxdue = 0;
      if (sh_kind == K_HOSTRX && was_due) begin
        acc.read_valid = 1'b1;
        acc.read_data = rx;
      end
      if (sh_fidx < nh) begin
        if (sh_fidx == 0) b = frame_opcode();
        else b = 8'(sh_addr >> (8 * (nh - 1 - sh_fidx)));
        sh_fidx++;
        last = (sh_fidx >= nh) && data_left() == 0;
      end else if (sh_kind == K_PROG) begin
        b = pl;
        acc.payload_taken = 1'b1;
        sh_addr++;
        if (sh_left != 0) sh_left--;
        if (sh_chunk != 0) sh_chunk--;
        last = sh_chunk == 0;
      end else begin
        b = DUMMY_BYTE;
        dummy = 1;
        sh_rxdue = 1;
        if (sh_kind == K_HOSTRX) begin
          if (sh_left != 0) sh_left--;
          last = sh_left == 0;
        end else begin
          if (sh_chunk != 0) sh_chunk--;
          last = sh_chunk == 0;
        end
      end
      acc.tx_valid = 1'b1;
      acc.tx_byte = b;
      acc.frame_last = last;
      if (last) close_frame(dummy);
    end else if (sh_phase == PH_RXTAIL) begin
      sh_rxdue = 0;
      if (sh_kind == K_HOSTRX) begin
        acc.read_valid = 1'b1;
        acc.read_data = rx;
        complete(ST_OK);
      end else if (!rx[0]) begin
        poll_clear();
      end else begin
        sh_phase = PH_POLLWAIT;
      end
    end
  endfunction

  function automatic void tick_step();
    if (sh_phase == PH_POLLWAIT) begin
      sh_elapsed++;
      if (sh_elapsed >= sh_limit) complete(ST_TIMEOUT);
      else open_frame(K_POLL);
    end else if (sh_phase == PH_WAKE) begin
      sh_elapsed++;
      if (sh_elapsed >= 3) complete(ST_OK);
    end
  endfunction

  function automatic result_t predict_result(logic [1:0] op, logic [3:0] c, logic [31:0] a,
                                             logic [26:0] n, logic [7:0] rx, logic [7:0] pl);
    acc = '0;
    case (op)
      OP_START: if (sh_phase == PH_IDLE) start_cmd(c, a, n);
      OP_SLOT:  slot_step(rx, pl);
      OP_TICK:  tick_step();
      default: ;
    endcase
    acc.busy_res = sh_phase != PH_IDLE;
    return acc;
  endfunction

  // Idle gaps: mostly none or short, now and then long.
  function automatic int gap_len();
    int p = $urandom_range(0, 99);
    if (quiet || p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [3:0] c, input logic [31:0] a,
                           input logic [26:0] n, input logic [7:0] rx, input logic [7:0] pl,
                           input bit typed, input result_t typed_res);
    int g;
    result_t pr;
    g = gap_len();
    if (g > 0) begin
      in_valid_i = 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    op_i = op;
    command_i = c;
    address_i = a;
    length_i = n;
    rx_byte_i = rx;
    payload_byte_i = pl;
    do @(posedge clk_i); while (in_stall_o);
    pr = predict_result(op, c, a, n, rx, pl);
    expected_q.push_back(typed ? typed_res : pr);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_DEVICE_MODEL) sh_model = val[2:0];
    else sh_timeout = val;
  endtask

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
    errors++;
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{tx_valid_o, tx_byte_o, frame_last_o, payload_taken_o, read_valid_o,
              read_data_o, done_res_o, status_o, busy_res_o};
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transaction", got, 0);
      end else begin
        want = expected_q.pop_front();
        if (got.tx_valid != want.tx_valid) report_mismatch("tx_valid", got.tx_valid, want.tx_valid);
        if (got.tx_byte != want.tx_byte) report_mismatch("tx_byte", got.tx_byte, want.tx_byte);
        if (got.frame_last != want.frame_last)
          report_mismatch("frame_last", got.frame_last, want.frame_last);
        if (got.payload_taken != want.payload_taken)
          report_mismatch("payload_taken", got.payload_taken, want.payload_taken);
        if (got.read_valid != want.read_valid)
          report_mismatch("read_valid", got.read_valid, want.read_valid);
        if (got.read_data != want.read_data)
          report_mismatch("read_data", got.read_data, want.read_data);
        if (got.done_res != want.done_res) report_mismatch("done_res", got.done_res, want.done_res);
        if (got.status != want.status) report_mismatch("status", got.status, want.status);
        if (got.busy_res != want.busy_res) report_mismatch("busy_res", got.busy_res, want.busy_res);
      end
    end
  end

  // Receiver stalls.
  initial begin
    int g;
    forever begin
      @(negedge clk_i);
      g = gap_len();
      out_stall_i = g > 0;
      if (g > 1) repeat (g - 1) @(negedge clk_i);
    end
  end

  // Directed rows: typed results where they are obvious, predictor elsewhere.
  typedef struct {
    logic [1:0]  op;
    logic [3:0]  c;
    logic [31:0] a;
    logic [26:0] n;
    logic [7:0]  rx;
    bit          typed;
    result_t     r;
  } dir_row_t;

  localparam result_t R_IDLE = '0;
  localparam result_t R_BUSY = '{0, 0, 0, 0, 0, 0, 0, ST_OK, 1};
  localparam result_t R_OK   = '{0, 0, 0, 0, 0, 0, 1, ST_OK, 0};
  localparam result_t R_RNG  = '{0, 0, 0, 0, 0, 0, 1, ST_RANGE, 0};

  dir_row_t rows[] = '{
    '{OP_SLOT,  0, 0, 0, 8'hFF, 1, R_IDLE},
    '{OP_TICK,  0, 0, 0, 0, 1, R_IDLE},
    '{OP_NONE,  4'hF, 32'hFFFF_FFFF, 27'h7FF_FFFF, 8'hFF, 1, R_IDLE},
    '{OP_START, CMD_READ, 0, 1, 0, 1, R_RNG},
    '{OP_START, CMD_WRITE, 0, 0, 0, 1, R_OK},
    '{OP_START, 4'd9, 0, 0, 0, 1, R_OK},
    '{OP_START, 4'hF, 32'hFFFF_FFFF, 27'h7FF_FFFF, 0, 1, R_OK},
    '{OP_START, CMD_SECTOR, 32'hFFFF_FFFF, 0, 0, 1, R_RNG},
    '{OP_START, CMD_ERASE32, 0, 0, 0, 1, R_RNG},
    '{OP_START, CMD_ERASE64, 0, 0, 0, 1, R_RNG},
    '{OP_START, CMD_STATUS, 0, 0, 0, 1, R_BUSY},
    '{OP_START, CMD_PDOWN, 0, 0, 0, 1, R_BUSY},
    '{OP_SLOT,  0, 0, 0, 0, 1, '{1, OPC_RDSR, 0, 0, 0, 0, 0, ST_OK, 1}},
    '{OP_SLOT,  0, 0, 0, 0, 1, '{1, DUMMY_BYTE, 1, 0, 0, 0, 0, ST_OK, 1}},
    '{OP_SLOT,  0, 0, 0, 8'hA5, 1, '{0, 0, 0, 0, 1, 8'hA5, 1, ST_OK, 0}},
    '{OP_START, CMD_PDOWN, 0, 0, 0, 1, R_BUSY},
    '{OP_SLOT,  0, 0, 0, 0, 1, '{1, OPC_PDOWN, 1, 0, 0, 0, 1, ST_OK, 0}},
    '{OP_START, CMD_PUP, 0, 0, 0, 1, R_BUSY},
    '{OP_SLOT,  0, 0, 0, 0, 1, '{1, OPC_PUP, 1, 0, 0, 0, 0, ST_OK, 1}},
    '{OP_TICK,  0, 0, 0, 0, 1, R_BUSY},
    '{OP_TICK,  0, 0, 0, 0, 1, R_BUSY},
    '{OP_TICK,  0, 0, 0, 0, 1, R_OK},
    '{OP_START, CMD_CHIP, 0, 0, 0, 0, R_IDLE},
    '{OP_SLOT,  0, 0, 0, 0, 0, R_IDLE},
    '{OP_SLOT,  0, 0, 0, 0, 0, R_IDLE}
  };

  // Address near a page or sector edge, mostly inside the part.
  function automatic logic [31:0] pick_address();
    logic [31:0] a;
    int p = $urandom_range(0, 99);
    if (p < 8 || sh_model == 0 || sh_model == 7) return $urandom;
    a = $urandom_range(0, (2097152 << (sh_model - 1)) - 1);
    if (p < 40) a = (a & 32'hFFFF_F000) | (p < 25 ? 0 : 32'h0000_8000);
    else if (p < 70) a = (a | 32'hFF) - $urandom_range(0, 20);
    else if (p < 78) a = (2097152 << (sh_model - 1)) - $urandom_range(0, 300);
    return a;
  endfunction

  // One well-formed command carried through to its end, with some noise mixed in.
  task automatic run_command();
    logic [3:0] c;
    logic [26:0] n;
    logic [7:0] rx;
    int guard;
    int p = $urandom_range(0, 99);
    c = (p < 90) ? $urandom_range(0, 8) : $urandom_range(9, 15);
    n = (c == CMD_WRITE) ? $urandom_range(0, 40) : $urandom_range(0, 6);
    if ($urandom_range(0, 30) == 0) n = $urandom;
    send_item(OP_START, c, pick_address(), n, $urandom, $urandom, 0, R_IDLE);
    guard = 0;
    while (sh_phase != PH_IDLE && guard < 400) begin
      guard++;
      rx = $urandom;
      if (sh_phase == PH_RXTAIL && sh_kind == K_POLL) rx[0] = $urandom_range(0, 9) < 4;
      p = $urandom_range(0, 99);
      if (p < 5)
        send_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 0, R_IDLE);
      else if (sh_phase == PH_POLLWAIT || sh_phase == PH_WAKE)
        send_item(p < 10 ? OP_SLOT : OP_TICK, 0, 0, 0, rx, $urandom, 0, R_IDLE);
      else
        send_item(p < 8 ? OP_TICK : OP_SLOT, 0, 0, 0, rx, $urandom, 0, R_IDLE);
    end
  endtask

  // Settings swept between phases: device model and busy timeout.
  int unsigned models[]   = '{1, 5, 6, 2, 3, 4, 0, 7, 6, 1};
  int unsigned timeouts[] = '{1, 3, 65535, 2, 0, 7, 4, 2, 1, 5};

  initial begin
    int sent;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (rows[i])
      send_item(rows[i].op, rows[i].c, rows[i].a, rows[i].n, rows[i].rx, 8'h00,
                rows[i].typed, rows[i].r);
    while (sh_phase != PH_IDLE)
      send_item(sh_phase == PH_POLLWAIT ? OP_TICK : OP_SLOT, 0, 0, 0, 8'h00, 0, 0, R_IDLE);
    foreach (models[i]) begin
      drain();
      write_reg(CFG_DEVICE_MODEL, 16'(models[i]));
      write_reg(CFG_BUSY_TIMEOUT, 16'(timeouts[i]));
      quiet = (i % 4) == 3;
      // At least 38 transactions per setting.
      sent = items_sent;
      while (items_sent - sent < 38) begin
        run_command();
      end
    end
    drain();
    repeat (20) @(negedge clk_i);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
`default_nettype wire
